// File: rtl/core/fxa_pkg.sv
// ----------------------------------------------------------------------------
// fxa_pkg
// Types, opcodes and operand formats for the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fxa_pkg;

  localparam int DataWidth = 32;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB  = 4'd1,  OP_MUL  = 4'd2,  OP_DIV   = 4'd3,
    OP_EQ   = 4'd4,  OP_NE   = 4'd5,  OP_GT   = 4'd6,  OP_LT    = 4'd7,
    OP_GE   = 4'd8,  OP_LE   = 4'd9,  OP_MIN  = 4'd10, OP_MAX   = 4'd11,
    OP_INC  = 4'd12, OP_DEC  = 4'd13, OP_FROM = 4'd14, OP_TO    = 4'd15
  } opcode_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               condition;
    logic               divide_by_zero;
  } out_beat_t;

  // Saturate a sign and an unsigned magnitude to the signed 32-bit range.
  function automatic logic [31:0] saturate(input logic neg, input logic [63:0] q);
    logic [31:0] r;
    if (neg) begin
      if (q >= 64'h8000_0000) r = 32'h8000_0000;
      else r = 32'd0 - q[31:0];
    end else begin
      if (q > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = q[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/fxa_div_cell.sv
// ----------------------------------------------------------------------------
// fxa_div_cell
// One stage of the pipelined divider and result chain: one restoring
// quotient bit per cell, with the finished beat riding alongside.
// ----------------------------------------------------------------------------
module fxa_div_cell
  import fxa_pkg::*;
#(
  parameter int QW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  logic [QW-1:0] rem_in,
  input  logic [QW-1:0] quo_in,
  input  logic [QW-1:0] num_in,
  input  logic [31:0]   den_in,
  input  logic [95:0]   side_in,
  output logic          valid_out,
  output logic [QW-1:0] rem_out,
  output logic [QW-1:0] quo_out,
  output logic [QW-1:0] num_out,
  output logic [31:0]   den_out,
  output logic [95:0]   side_out
);

  logic [QW:0] trial;
  logic [QW:0] diff;

  // Shift in the next numerator bit and try one subtract.
  assign trial = {rem_in, num_in[QW-1]};
  assign diff  = trial - {{(QW-31){1'b0}}, den_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!diff[QW]) begin
        rem_out <= diff[QW-1:0];
      end else begin
        rem_out <= trial[QW-1:0];
      end
      quo_out  <= {quo_in[QW-2:0], ~diff[QW]};
      num_out  <= {num_in[QW-2:0], 1'b0};
      den_out  <= den_in;
      side_out <= side_in;
    end
  end

endmodule

// File: rtl/core/fixed_point_alu_q24_8.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// One beat enters per cycle and results leave in order, one per cycle, while
// the pipe is not stalled. Each beat passes a front stage (decode, simple ops,
// operand magnitudes), a product stage, a chain of 32+FRAC_BITS divider cells
// that each produce one quotient bit, and a final rounding and saturation
// stage. The whole pipe advances when the output register is empty or being
// taken; ready follows that.
module fixed_point_alu_q24_8
  import fxa_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int QW = 32 + FRAC_BITS;
  localparam int NC = QW;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Front stage: decode and simple results, multiply magnitudes.
  logic [31:0] a, b, ma, mb, simple;
  logic        cond, neg, is_mul, is_div, dz;
  opcode_t     op;
  assign op = opcode_t'(in_data.opcode);
  assign a  = in_data.operand_a;
  assign b  = in_data.operand_b;
  assign ma = a[31] ? 32'd0 - a : a;
  assign mb = b[31] ? 32'd0 - b : b;

  always_comb begin
    simple = '0;
    cond   = 1'b0;
    unique case (op)
      OP_ADD:  simple = a + b;
      OP_SUB:  simple = a - b;
      OP_EQ:   cond = (a == b);
      OP_NE:   cond = (a != b);
      OP_GT:   cond = ($signed(a) > $signed(b));
      OP_LT:   cond = ($signed(a) < $signed(b));
      OP_GE:   cond = ($signed(a) >= $signed(b));
      OP_LE:   cond = ($signed(a) <= $signed(b));
      OP_MIN:  simple = ($signed(a) < $signed(b)) ? a : b;
      OP_MAX:  simple = ($signed(a) > $signed(b)) ? a : b;
      OP_INC:  simple = a + 32'd1;
      OP_DEC:  simple = a - 32'd1;
      OP_FROM: simple = a << FRAC_BITS;
      OP_TO:   simple = $unsigned($signed(a) >>> FRAC_BITS);
      default: simple = '0;
    endcase
  end
  assign neg    = a[31] ^ b[31];
  assign is_mul = (op == OP_MUL);
  assign is_div = (op == OP_DIV);
  assign dz     = is_div && (b == 32'd0);

  logic        s0_valid;
  logic [31:0] s0_ma, s0_mb, s0_simple, s0_den;
  logic        s0_cond, s0_neg, s0_mul, s0_div, s0_dz;
  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else if (en) s0_valid <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_ma <= ma; s0_mb <= mb; s0_simple <= simple;
      s0_den <= dz ? 32'd1 : mb;
      s0_cond <= cond; s0_neg <= neg; s0_mul <= is_mul;
      s0_div <= is_div && !dz; s0_dz <= dz;
    end
  end

  // Product stage: one 32x32 multiply, registered.
  logic        s1_valid;
  logic [63:0] s1_prod;
  logic [QW-1:0] s1_num;
  logic [31:0] s1_den;
  logic [95:0] s1_side;
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= s0_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= s0_ma * s0_mb;
      s1_num  <= {s0_ma, {FRAC_BITS{1'b0}}};
      s1_den  <= s0_den;
      s1_side <= {59'd0, s0_simple, s0_cond, s0_neg, s0_mul, s0_div, s0_dz};
    end
  end

  // Carry the product in the side channel: rebuild side with it.
  logic [95:0] s1_side_full;
  assign s1_side_full = {s1_prod[58:0], s1_side[36:0]};
  logic [4:0] s1_prod_hi;
  assign s1_prod_hi = s1_prod[63:59];

  // Divider chain.
  logic          cv [NC+1];
  logic [QW-1:0] cr [NC+1];
  logic [QW-1:0] cq [NC+1];
  logic [QW-1:0] cn [NC+1];
  logic [31:0]   cd [NC+1];
  logic [95:0]   cs [NC+1];
  logic [4:0]    ph [NC+1];
  assign cv[0] = s1_valid;
  assign cr[0] = '0;
  assign cq[0] = '0;
  assign cn[0] = s1_num;
  assign cd[0] = s1_den;
  assign cs[0] = s1_side_full;
  assign ph[0] = s1_prod_hi;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    fxa_div_cell #(.QW(QW)) u_cell (
      .clk, .rst, .en,
      .valid_in(cv[i]), .rem_in(cr[i]), .quo_in(cq[i]), .num_in(cn[i]),
      .den_in(cd[i]), .side_in(cs[i]),
      .valid_out(cv[i+1]), .rem_out(cr[i+1]), .quo_out(cq[i+1]),
      .num_out(cn[i+1]), .den_out(cd[i+1]), .side_out(cs[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) ph[i+1] <= ph[i];
    end
  end

  // Final stage: round, saturate, select.
  logic [63:0] prod, mq, dq;
  logic [31:0] fsimple;
  logic [QW:0] rem2;
  out_beat_t   fin;
  assign prod    = {ph[NC], cs[NC][95:37]};
  assign fsimple = cs[NC][36:5];
  assign mq      = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rem2    = {cr[NC], 1'b0};
  assign dq      = {{(64-QW){1'b0}}, cq[NC]}
                 + {63'd0, (rem2 >= {{(QW-31){1'b0}}, cd[NC]})};

  always_comb begin
    fin.condition      = cs[NC][4];
    fin.divide_by_zero = cs[NC][0];
    if (cs[NC][2]) fin.result_value = saturate(cs[NC][3], mq);
    else if (cs[NC][1]) fin.result_value = saturate(cs[NC][3], dq);
    else if (cs[NC][0]) fin.result_value = '0;
    else fin.result_value = fsimple;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= cv[NC];
  end
  always_ff @(posedge clk) begin
    if (en) out_data <= fin;
  end

endmodule
